// ===== src/sti_pkg.sv =====
// Shared types and constants for the segment/triangle intersection unit.
`default_nettype none
package sti_pkg;
   localparam int CmdW = 3;
   localparam int OutCoordW = 32;
   localparam int DistW = 31;
   localparam int FracOutW = 17;
   localparam logic [CmdW-1:0] CMD_PLANE = 3'd0;
   localparam logic [CmdW-1:0] CMD_VA    = 3'd1;
   localparam logic [CmdW-1:0] CMD_VB    = 3'd2;
   localparam logic [CmdW-1:0] CMD_VC    = 3'd3;
   localparam logic [CmdW-1:0] CMD_START = 3'd4;
   localparam logic [CmdW-1:0] CMD_TEST  = 3'd5;

   typedef struct packed {
      logic [CmdW-1:0]   command;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
      logic signed [31:0] plane_offset;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] hit_x;
      logic signed [31:0] hit_y;
      logic signed [31:0] hit_z;
      logic [DistW-1:0]   hit_distance;
      logic [FracOutW-1:0] hit_fraction;
   } rsp_type;
endpackage
`default_nettype wire

// ===== src/sti_if.sv =====
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface sti_req_if;
   logic valid;
   logic ready;
   sti_pkg::req_type req;
   modport source (output valid, output req, input ready);
   modport sink (input valid, input req, output ready);
endinterface

interface sti_rsp_if;
   logic valid;
   logic ready;
   sti_pkg::rsp_type rsp;
   modport source (output valid, output rsp, input ready);
   modport sink (input valid, input rsp, output ready);
endinterface
`default_nettype wire

// ===== src/sti_front.sv =====
// Front end: accepts beats, drops unknown commands, feeds a two-entry queue.
`default_nettype none
module sti_front (
   input  wire logic clock,
   input  wire logic reset,
   sti_req_if.sink   req_ch,
   output sti_pkg::req_type q_data,
   output logic      q_valid,
   input  wire logic q_pop
);
   import sti_pkg::*;
   req_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, known;

   assign known = (req_ch.req.command <= CMD_TEST);
   assign req_ch.ready = (cnt_ff != 2'd2);
   assign push = req_ch.valid && req_ch.ready && known;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ (q_pop && q_valid);
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= req_ch.req;
   end
endmodule
`default_nettype wire

// ===== src/sti_back.sv =====
// Back end: holds the geometry and runs the intersection test sequencer.
`default_nettype none
module sti_back #(
   parameter int FRAC_BITS = 16,
   parameter int COORD_WIDTH = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  sti_pkg::req_type q_data,
   input  wire logic q_valid,
   output logic      q_pop,
   sti_rsp_if.source rsp_ch
);
   import sti_pkg::*;
   localparam int PW = 72;     // plane distance / edge arithmetic width
   localparam int WW = 100;    // squared length width
   localparam int RW = 42;     // square root result
   localparam int SW = 34;     // point coordinate width

   localparam logic [3:0] ST_IDLE = 4'd0, ST_D0 = 4'd1, ST_D1 = 4'd2, ST_TDIV = 4'd3,
      ST_PT = 4'd4, ST_EDGE = 4'd5, ST_SQ = 4'd6, ST_SQRT = 4'd7,
      ST_FDIV = 4'd8, ST_OUT = 4'd9;

   logic signed [31:0] pl_ff [4];
   logic signed [31:0] vx_ff [9];
   logic signed [31:0] sp_ff [3];
   logic signed [31:0] p1_ff [3];
   logic [3:0]  st_ff;
   logic [1:0]  k_ff;           // sub-step counter
   logic [6:0]  it_ff;
   logic signed [PW-1:0] acc_ff, d0_ff;
   logic [PW-1:0] num_ff, den_ff, rem_ff;
   logic [FRAC_BITS:0] q_ff;
   logic signed [SW-1:0] pt_ff [3];
   logic signed [PW-1:0] prod_ff;
   logic ok_ff;
   logic [WW-1:0] sq_ff, sqn_ff;
   logic [RW-1:0] root_ff, dist_ff;
   logic rsp_v_ff;
   rsp_type rsp_ff;
   logic [1:0] ai, bi;
   logic [3:0] ebase_i, ebase_j;

   // projection axes from the dominant normal component and its sign
   function automatic logic [63:0] mag(input logic signed [31:0] v);
      mag = v[31] ? 64'(-64'(v)) : 64'(v);
   endfunction
   always_comb begin
      logic [63:0] ax, ay, az;
      ax = mag(pl_ff[0]); ay = mag(pl_ff[1]); az = mag(pl_ff[2]);
      if (ay < ax) begin
         if (az < ax) begin
            ai = pl_ff[0] <= 0 ? 2'd1 : 2'd2; bi = pl_ff[0] <= 0 ? 2'd2 : 2'd1;
         end else begin
            ai = pl_ff[2] <= 0 ? 2'd0 : 2'd1; bi = pl_ff[2] <= 0 ? 2'd1 : 2'd0;
         end
      end else if (az < ay) begin
         ai = pl_ff[1] <= 0 ? 2'd2 : 2'd0; bi = pl_ff[1] <= 0 ? 2'd0 : 2'd2;
      end else begin
         ai = pl_ff[2] > 0 ? 2'd1 : 2'd0; bi = pl_ff[2] > 0 ? 2'd0 : 2'd1;
      end
   end

   always_comb begin
      unique case (k_ff)
         2'd0: begin ebase_i = 4'd0; ebase_j = 4'd3; end
         2'd1: begin ebase_i = 4'd3; ebase_j = 4'd6; end
         default: begin ebase_i = 4'd6; ebase_j = 4'd0; end
      endcase
   end

   logic signed [63:0] prod_dot;
   logic signed [31:0] pcoord;
   logic signed [SW-1:0] evi_a, evi_b, evj_a, evj_b, eq_a, eq_b;
   logic signed [PW-1:0] e1, e2;
   logic signed [SW:0] dif;
   logic [RW-1:0] cand;
   logic [WW-1:0] cand_step;
   always_comb begin
      pcoord = (st_ff == ST_D0) ? sp_ff[k_ff] : p1_ff[k_ff];
      prod_dot = 64'(pl_ff[k_ff]) * 64'(pcoord);
      evi_a = SW'(vx_ff[ebase_i + 4'(ai)]); evi_b = SW'(vx_ff[ebase_i + 4'(bi)]);
      evj_a = SW'(vx_ff[ebase_j + 4'(ai)]); evj_b = SW'(vx_ff[ebase_j + 4'(bi)]);
      eq_a = pt_ff[ai]; eq_b = pt_ff[bi];
      e1 = PW'(evj_a - evi_a) * PW'(eq_b - evj_b);
      e2 = PW'(eq_a - evj_a) * PW'(evj_b - evi_b);
      dif = (SW+1)'(p1_ff[k_ff]) - (SW+1)'(sp_ff[k_ff]);
      // trial bit b: (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
      cand = root_ff | (RW'(1) << it_ff[5:0]);
      cand_step = (WW'(root_ff) << (7'(it_ff[5:0]) + 7'd1))
                + (WW'(1) << {it_ff[5:0], 1'b0});
   end

   // selects the difference for the length sums: it_ff[1] picks p1 vs point
   logic signed [SW:0] ldif;
   assign ldif = it_ff[1] ? (SW+1)'(p1_ff[k_ff]) - (SW+1)'(sp_ff[k_ff])
                          : (SW+1)'(pt_ff[k_ff]) - (SW+1)'(sp_ff[k_ff]);

   assign q_pop = q_valid && (st_ff == ST_IDLE) && !rsp_v_ff;
   assign rsp_ch.valid = rsp_v_ff;
   assign rsp_ch.rsp = rsp_ff;

   function automatic logic signed [31:0] sat(input logic signed [SW-1:0] v);
      localparam int W = COORD_WIDTH < 32 ? COORD_WIDTH : 32;
      logic signed [SW-1:0] hi, lo;
      hi = SW'((64'sd1 <<< (W-1)) - 1);
      lo = -hi - 1;
      sat = v > hi ? 32'(hi) : (v < lo ? 32'(lo) : 32'(v));
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rsp_v_ff <= 1'b0;
         for (int i = 0; i < 4; i++) pl_ff[i] <= '0;
         for (int i = 0; i < 9; i++) vx_ff[i] <= '0;
         for (int i = 0; i < 3; i++) sp_ff[i] <= '0;
      end else begin
         if (rsp_v_ff && rsp_ch.ready) rsp_v_ff <= 1'b0;
         unique case (st_ff)
            ST_IDLE: if (q_pop) begin
               unique case (q_data.command)
                  CMD_PLANE: begin
                     pl_ff[0] <= q_data.coord_x; pl_ff[1] <= q_data.coord_y;
                     pl_ff[2] <= q_data.coord_z; pl_ff[3] <= q_data.plane_offset;
                  end
                  CMD_VA, CMD_VB, CMD_VC: begin
                     vx_ff[4'(3*(q_data.command-1))]   <= q_data.coord_x;
                     vx_ff[4'(3*(q_data.command-1)+1)] <= q_data.coord_y;
                     vx_ff[4'(3*(q_data.command-1)+2)] <= q_data.coord_z;
                  end
                  CMD_START: begin
                     sp_ff[0] <= q_data.coord_x; sp_ff[1] <= q_data.coord_y;
                     sp_ff[2] <= q_data.coord_z;
                  end
                  default: begin
                     p1_ff[0] <= q_data.coord_x; p1_ff[1] <= q_data.coord_y;
                     p1_ff[2] <= q_data.coord_z;
                     acc_ff <= PW'(pl_ff[3]);
                     k_ff <= 2'd0;
                     st_ff <= ST_D0;
                  end
               endcase
            end
            ST_D0, ST_D1: begin
               // accumulate one floored product per cycle
               if (k_ff == 2'd2) begin
                  k_ff <= 2'd0;
                  if (st_ff == ST_D0) begin
                     d0_ff <= acc_ff + PW'(prod_dot >>> FRAC_BITS);
                     acc_ff <= PW'(pl_ff[3]);
                     st_ff <= ST_D1;
                  end else begin
                     logic signed [PW-1:0] d1;
                     logic [PW-1:0] m0, m1;
                     d1 = acc_ff + PW'(prod_dot >>> FRAC_BITS);
                     m0 = d0_ff[PW-1] ? PW'(-d0_ff) : PW'(d0_ff);
                     m1 = d1[PW-1] ? PW'(-d1) : PW'(d1);
                     if (d0_ff[PW-1] == d1[PW-1]) begin
                        rsp_ff <= '0; rsp_v_ff <= 1'b1; st_ff <= ST_IDLE;
                     end else begin
                        num_ff <= m0; den_ff <= m0 + m1; rem_ff <= m0;
                        q_ff <= '0; it_ff <= '0; st_ff <= ST_TDIV;
                     end
                  end
               end else begin
                  acc_ff <= acc_ff + PW'(prod_dot >>> FRAC_BITS);
                  k_ff <= k_ff + 2'd1;
               end
            end
            ST_TDIV: begin
               // restoring divider, registers shared with ST_FDIV: one quotient bit per cycle
               if (num_ff >= den_ff) begin
                  q_ff <= (FRAC_BITS+1)'(1) << FRAC_BITS; it_ff <= '0; k_ff <= 2'd0;
                  num_ff <= '0; st_ff <= ST_PT;
               end else if (it_ff == 7'(FRAC_BITS)) begin
                  it_ff <= '0; k_ff <= 2'd0; st_ff <= ST_PT;
               end else begin
                  logic [PW-1:0] r2;
                  r2 = rem_ff << 1;
                  if (r2 >= den_ff) begin
                     rem_ff <= r2 - den_ff; q_ff <= {q_ff[FRAC_BITS-1:0], 1'b1};
                  end else begin
                     rem_ff <= r2; q_ff <= {q_ff[FRAC_BITS-1:0], 1'b0};
                  end
                  it_ff <= it_ff + 7'd1;
               end
            end
            ST_PT: begin
               // multiply in one cycle, add in the next
               if (it_ff[0] == 1'b0) begin
                  prod_ff <= PW'(dif) * PW'($signed({1'b0, q_ff}));
                  it_ff[0] <= 1'b1;
               end else begin
                  pt_ff[k_ff] <= SW'(sp_ff[k_ff]) + SW'(prod_ff >>> FRAC_BITS);
                  it_ff[0] <= 1'b0;
                  if (k_ff == 2'd2) begin
                     k_ff <= 2'd0; ok_ff <= 1'b1; st_ff <= ST_EDGE;
                  end else k_ff <= k_ff + 2'd1;
               end
            end
            ST_EDGE: begin
               logic signed [PW-1:0] e;
               e = e1 - e2;
               if (!(e[PW-1] || e == '0) || (evi_a == evj_a && evi_b == evj_b))
                  ok_ff <= 1'b0;
               if (k_ff == 2'd2) begin
                  k_ff <= 2'd0;
                  if (!ok_ff || !(e[PW-1] || e == '0)
                      || (evi_a == evj_a && evi_b == evj_b)) begin
                     rsp_ff <= '0; rsp_v_ff <= 1'b1; st_ff <= ST_IDLE;
                  end else begin
                     sq_ff <= '0; it_ff <= '0; st_ff <= ST_SQ;
                  end
               end else k_ff <= k_ff + 2'd1;
            end
            ST_SQ: begin
               // it_ff[1] = 0: point length, 1: segment length
               sq_ff <= sq_ff + WW'(ldif) * WW'(ldif);
               if (k_ff == 2'd2) begin
                  k_ff <= 2'd0; root_ff <= '0;
                  sqn_ff <= sq_ff + WW'(ldif) * WW'(ldif);
                  it_ff <= {it_ff[1], 6'd40};
                  st_ff <= ST_SQRT;
               end else k_ff <= k_ff + 2'd1;
            end
            ST_SQRT: begin
               // one result bit per cycle; sqn_ff holds what is left of the square
               logic [RW-1:0] r;
               if (cand_step <= sqn_ff) begin
                  r = cand;
                  sqn_ff <= sqn_ff - cand_step;
               end else r = root_ff;
               root_ff <= r;
               if (it_ff[5:0] == 6'd0) begin
                  if (it_ff[6] == 1'b0) begin
                     dist_ff <= r; sq_ff <= '0; it_ff <= 7'b0000010; st_ff <= ST_SQ;
                  end else begin
                     num_ff <= PW'(dist_ff); den_ff <= PW'(r); rem_ff <= PW'(dist_ff);
                     q_ff <= '0; it_ff <= '0; st_ff <= ST_FDIV;
                  end
               end else it_ff[5:0] <= it_ff[5:0] - 6'd1;
            end
            ST_FDIV: begin
               if (den_ff == '0) begin
                  q_ff <= '0; st_ff <= ST_OUT;
               end else if (num_ff >= den_ff) begin
                  q_ff <= (FRAC_BITS+1)'(1) << FRAC_BITS; st_ff <= ST_OUT;
               end else if (it_ff == 7'(FRAC_BITS)) st_ff <= ST_OUT;
               else begin
                  logic [PW-1:0] r2;
                  r2 = rem_ff << 1;
                  if (r2 >= den_ff) begin
                     rem_ff <= r2 - den_ff; q_ff <= {q_ff[FRAC_BITS-1:0], 1'b1};
                  end else begin
                     rem_ff <= r2; q_ff <= {q_ff[FRAC_BITS-1:0], 1'b0};
                  end
                  it_ff <= it_ff + 7'd1;
               end
            end
            ST_OUT: begin
               rsp_ff.hit <= 1'b1;
               rsp_ff.hit_x <= sat(pt_ff[0]);
               rsp_ff.hit_y <= sat(pt_ff[1]);
               rsp_ff.hit_z <= sat(pt_ff[2]);
               rsp_ff.hit_distance <= (dist_ff > RW'(31'h7FFFFFFF)) ? 31'h7FFFFFFF
                                      : DistW'(dist_ff);
               rsp_ff.hit_fraction <= (FRAC_BITS + 1 > FracOutW &&
                                       q_ff > (FRAC_BITS+1)'(17'h1FFFF))
                                      ? 17'h1FFFF : FracOutW'(q_ff);
               rsp_v_ff <= 1'b1;
               st_ff <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== src/segment_triangle_intersection_unit.sv =====
// Top level of the segment/triangle intersection unit.
// A test beat runs the bit-serial divider twice and the bit-serial square root
// (41 steps) twice. One test runs at a time. Throughput: a load beat every
// cycle while the back end is idle and holds no response beat; a running
// test or an unaccepted response stalls the queue.
// Reset (synchronous, active high) clears plane, vertices and start point to zero.
`default_nettype none
module segment_triangle_intersection_unit #(
   parameter int FRAC_BITS = 16,
   parameter int COORD_WIDTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   sti_req_if.sink   req,
   sti_rsp_if.source rsp
);
   import sti_pkg::*;
   req_type q_data;
   logic    q_valid, q_pop;

   // front end: take beats, drop unknown commands, buffer for the back end
   sti_front u_front (
      .clock, .reset, .req_ch(req), .q_data, .q_valid, .q_pop
   );

   // back end: store geometry, run the test, hold the result beat
   sti_back #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock, .reset, .q_data, .q_valid, .q_pop, .rsp_ch(rsp)
   );
endmodule
`default_nettype wire
